// ===== hw/rtl/lts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the tail percentile statistics block.
// No dependencies; imported by every other file of the block.
package lts_pkg;

   localparam int unsigned SAMPLE_W    = 32;
   localparam int unsigned PCT_IDX_W   = 5;
   localparam int unsigned CNT_OUT_W   = 13;
   localparam int unsigned SUM_W       = 44;
   localparam int unsigned AVG_W       = 40;
   localparam int unsigned FRAC_W      = 8;
   localparam int unsigned DIV_W       = SUM_W + FRAC_W;
   localparam int unsigned NUM_PCT     = 19;
   localparam int unsigned PCT_SCALE   = 10000;
   localparam int unsigned TAIL_DIV    = 100;
   localparam int unsigned Q_W         = 7;
   localparam int unsigned RANK_W      = 48;
   localparam int unsigned RANK_SHIFT  = 37;

   localparam logic [PCT_IDX_W-1:0] LAST_IDX = PCT_IDX_W'(NUM_PCT - 1);

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_REPORT = 1'b1;

   // share of the window above each percentile, in units of 0.01 percent
   localparam logic [Q_W-1:0] TAIL_SHARE [NUM_PCT] = '{
      7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10,
      7'd9, 7'd8, 7'd7, 7'd6, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1
   };

   // TAIL_SHARE scaled by ceil(2^37 / 10000); count times this plus RANK_ROUND,
   // shifted right by RANK_SHIFT, gives ceil(count * share / 10000)
   localparam logic [31:0] RANK_COEF [NUM_PCT] = '{
      32'd1374389600, 32'd1236950640, 32'd1099511680, 32'd962072720,
      32'd824633760, 32'd687194800, 32'd549755840, 32'd412316880,
      32'd274877920, 32'd137438960, 32'd123695064, 32'd109951168,
      32'd96207272, 32'd82463376, 32'd68719480, 32'd54975584,
      32'd41231688, 32'd27487792, 32'd13743896
   };
   localparam logic [RANK_W-1:0] RANK_ROUND = 48'd137425216104;

   typedef struct packed {
      logic insert;
      logic shift;
      logic clear;
   } cell_ctrl_type;

   typedef enum logic [5:0] {
      ST_COLLECT = 6'b000001,
      ST_AVG     = 6'b000010,
      ST_RANK    = 6'b000100,
      ST_RWAIT   = 6'b001000,
      ST_SEEK    = 6'b010000,
      ST_SEND    = 6'b100000
   } state_type;

endpackage

// ===== hw/rtl/lts_req_if.sv =====
`timescale 1ns / 1ps
// Request channel: latency samples and report requests.
// Depends on lts_pkg.
interface lts_req_if;
   import lts_pkg::*;

   logic                valid;
   logic                ready;
   logic                req_type;
   logic [SAMPLE_W-1:0] latency_sample;

   modport source (output valid, output req_type, output latency_sample, input ready);
   modport sink   (input valid, input req_type, input latency_sample, output ready);
endinterface

// ===== hw/rtl/lts_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel: one transaction per tail percentile of a report.
// Depends on lts_pkg.
interface lts_rsp_if;
   import lts_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [PCT_IDX_W-1:0] percentile_index;
   logic [SAMPLE_W-1:0]  percentile_value;
   logic [CNT_OUT_W-1:0] sample_count;
   logic [SUM_W-1:0]     latency_sum;
   logic [AVG_W-1:0]     average_fixed;
   logic [SAMPLE_W-1:0]  maximum;
   logic                 overflowed;
   logic                 last;

   modport source (output valid, output percentile_index, output percentile_value,
                   output sample_count, output latency_sum, output average_fixed,
                   output maximum, output overflowed, output last, input ready);
   modport sink   (input valid, input percentile_index, input percentile_value,
                   input sample_count, input latency_sum, input average_fixed,
                   input maximum, input overflowed, input last, output ready);
endinterface

// ===== hw/rtl/lts_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted chain that keeps the largest samples, largest first.
// Depends on lts_pkg for the cell control struct.
module lts_cell #(
   parameter int unsigned WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lts_pkg::cell_ctrl_type ctrl,
   input  logic [WIDTH-1:0]      sample,
   input  logic                  prev_valid,
   input  logic [WIDTH-1:0]      prev_value,
   input  logic                  prev_above,
   output logic                  valid,
   output logic [WIDTH-1:0]      value,
   output logic                  above
);
   import lts_pkg::*;

   logic             valid_ff, valid_in;
   logic [WIDTH-1:0] value_ff, value_in;

   assign above = !valid_ff || (sample > value_ff);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift || (ctrl.insert && prev_above)) begin
         valid_in = prev_valid;
         value_in = prev_value;
      end else if (ctrl.insert && above) begin
         valid_in = 1'b1;
         value_in = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
endmodule

// ===== hw/rtl/lts_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on lts_pkg for the dividend width.
module lts_div #(
   parameter int unsigned DIVISOR_W = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lts_pkg::DIV_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]      divisor,
   output logic                      done,
   output logic [lts_pkg::DIV_W-1:0] quotient
);
   import lts_pkg::*;

   localparam int unsigned STEP_W = $clog2(DIV_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = !diff[DIVISOR_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== hw/rtl/latency_tail_percentile_stats.sv =====
`timescale 1ns / 1ps
// Tail latency percentile statistics over one reporting window.
// Depends on lts_pkg, lts_req_if, lts_rsp_if, lts_cell and lts_div.
//
// req_if carries sample transactions (req_type 0) and report transactions
// (req_type 1). While the block collects, a new sample can follow every cycle;
// each updates count and sum and drops into a sorted chain of cells that
// keeps the largest ceil(MAX_SAMPLES/100) samples, which hold every tail
// percentile position. Once MAX_SAMPLES are held, further samples are dropped
// and flagged.
// A report produces 19 rsp_if transactions, percentile 99.0 first, with last
// on the 99.99 one, then clears the window. For the average a serial divider
// runs first; each result then finds its rank in ST_RANK and ST_RWAIT, takes
// the chain shifts that bring that rank to the chain end, is loaded into the
// output register in ST_SEEK and is handed over in ST_SEND. The shifts add
// up to at most ceil(MAX_SAMPLES/100) per report. req_if.ready is low for the
// whole report. While rsp_if.ready is low the result holds in the output
// register and the report waits. Reset empties the window at once.
module latency_tail_percentile_stats #(
   parameter int unsigned MAX_SAMPLES = 4096,
   parameter int unsigned SAMPLE_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   lts_req_if.sink   req_if,
   lts_rsp_if.source rsp_if
);
   import lts_pkg::*;

   localparam int unsigned SW         = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int unsigned TAIL_DEPTH = (MAX_SAMPLES + TAIL_DIV - 1) / TAIL_DIV;
   localparam int unsigned CW         = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned SHW        = $clog2(TAIL_DEPTH + 1);
   localparam int unsigned CXW        = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                drop_ff, drop_in;
   logic [PCT_IDX_W-1:0] k_ff, k_in;
   logic [SHW-1:0]      shift_ff, shift_in;
   logic [SHW-1:0]      target_ff, target_in;
   logic [AVG_W-1:0]    avg_ff, avg_in;
   logic [SW-1:0]       max_ff, max_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]       rsp_value_ff, rsp_value_in;

   cell_ctrl_type       ctrl;
   logic [SW-1:0]       sample;
   logic                req_fire;
   logic                rsp_fire;
   logic                full;
   logic                empty;
   logic [SUM_W:0]      sum_wide;
   logic [RANK_W-1:0]   rank_mul;
   logic [CXW-1:0]      count_ext;

   logic                div_start;
   logic [DIV_W-1:0]    div_dividend;
   logic [CW-1:0]       div_divisor;
   logic                div_done;
   logic [DIV_W-1:0]    div_quotient;

   logic                link_valid [TAIL_DEPTH+1];
   logic [SW-1:0]       link_value [TAIL_DEPTH+1];
   logic                link_above [TAIL_DEPTH+1];

   assign sample    = req_if.latency_sample[SW-1:0];
   assign req_fire  = req_if.valid && req_if.ready;
   assign rsp_fire  = rsp_valid_ff && rsp_if.ready;
   assign full      = (count_ff == CW'(MAX_SAMPLES));
   assign empty     = (count_ff == '0);
   assign sum_wide  = {1'b0, sum_ff} + (SUM_W + 1)'(sample);
   assign rank_mul  = RANK_W'(count_ff) * RANK_W'(RANK_COEF[k_ff]) + RANK_ROUND;
   assign count_ext = CXW'(count_ff);

   assign link_valid[0] = 1'b0;
   assign link_value[0] = '0;
   assign link_above[0] = 1'b0;

   for (genvar i = 0; i < TAIL_DEPTH; i++) begin : g_cell
      lts_cell #(
         .WIDTH (SW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .sample     (sample),
         .prev_valid (link_valid[i]),
         .prev_value (link_value[i]),
         .prev_above (link_above[i]),
         .valid      (link_valid[i+1]),
         .value      (link_value[i+1]),
         .above      (link_above[i+1])
      );
   end

   lts_div #(
      .DIVISOR_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      drop_in      = drop_ff;
      k_in         = k_ff;
      shift_in     = shift_ff;
      target_in    = target_ff;
      avg_in       = avg_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      ctrl         = '0;
      div_start    = 1'b0;
      div_dividend = {sum_ff, FRAC_W'(0)};
      div_divisor  = count_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_fire) begin
               if (req_if.req_type == REQ_SAMPLE) begin
                  if (full) begin
                     drop_in = 1'b1;
                  end else begin
                     ctrl.insert = 1'b1;
                     count_in    = count_ff + 1'b1;
                     sum_in      = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                  end
               end else begin
                  max_in    = link_valid[1] ? link_value[1] : '0;
                  div_start = 1'b1;
                  state_in  = ST_AVG;
               end
            end
         end
         ST_AVG: begin
            if (div_done) begin
               if (empty) begin
                  avg_in = '0;
               end else if (|div_quotient[DIV_W-1:AVG_W]) begin
                  avg_in = '1;
               end else begin
                  avg_in = div_quotient[AVG_W-1:0];
               end
               k_in     = '0;
               shift_in = '0;
               state_in = ST_RANK;
            end
         end
         ST_RANK: begin
            target_in = SHW'(rank_mul >> RANK_SHIFT);
            state_in  = ST_RWAIT;
         end
         ST_RWAIT: begin
            target_in = SHW'(TAIL_DEPTH) - target_ff;
            state_in  = ST_SEEK;
         end
         ST_SEEK: begin
            if (empty || shift_ff == target_ff) begin
               rsp_value_in = empty ? '0 : link_value[TAIL_DEPTH];
               rsp_valid_in = 1'b1;
               state_in     = ST_SEND;
            end else begin
               ctrl.shift = 1'b1;
               shift_in   = shift_ff + 1'b1;
            end
         end
         ST_SEND: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (k_ff == LAST_IDX) begin
                  ctrl.clear = 1'b1;
                  count_in   = '0;
                  sum_in     = '0;
                  drop_in    = 1'b0;
                  state_in   = ST_COLLECT;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_RANK;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         count_ff     <= '0;
         sum_ff       <= '0;
         drop_ff      <= 1'b0;
         k_ff         <= '0;
         shift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         drop_ff      <= drop_in;
         k_ff         <= k_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff    <= target_in;
      avg_ff       <= avg_in;
      max_ff       <= max_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_if.ready = (state_ff == ST_COLLECT);

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.percentile_index = k_ff;
   assign rsp_if.percentile_value = SAMPLE_W'(rsp_value_ff);
   assign rsp_if.sample_count     = (count_ext > CXW'(2**CNT_OUT_W - 1)) ? '1
                                                                        : count_ext[CNT_OUT_W-1:0];
   assign rsp_if.latency_sum      = sum_ff;
   assign rsp_if.average_fixed    = avg_ff;
   assign rsp_if.maximum          = SAMPLE_W'(max_ff);
   assign rsp_if.overflowed       = drop_ff;
   assign rsp_if.last             = (k_ff == LAST_IDX);
endmodule

// ===== hw/rtl/lts_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks for the tail percentile statistics block, bound to the top.
// Depends on lts_pkg and latency_tail_percentile_stats.
module lts_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lts_pkg::PCT_IDX_W-1:0] percentile_index,
   input logic [lts_pkg::SAMPLE_W-1:0]  percentile_value,
   input logic [lts_pkg::CNT_OUT_W-1:0] sample_count,
   input logic [lts_pkg::AVG_W-1:0]     average_fixed,
   input logic [lts_pkg::SAMPLE_W-1:0]  maximum,
   input logic                          last
);
   import lts_pkg::*;

   hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(percentile_index)
         && $stable(percentile_value) && $stable(last))
      else $error("stalled transaction changed");

   no_intake_in_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a report is out");

   last_on_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last == (percentile_index == LAST_IDX)))
      else $error("last does not match final percentile");

   value_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> percentile_value <= maximum)
      else $error("percentile value above maximum");

   empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sample_count == '0 |-> percentile_value == '0 && maximum == '0
         && average_fixed == '0)
      else $error("empty window reported nonzero");
endmodule

bind latency_tail_percentile_stats lts_chk u_lts_chk (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .percentile_index (rsp_if.percentile_index),
   .percentile_value (rsp_if.percentile_value),
   .sample_count     (rsp_if.sample_count),
   .average_fixed    (rsp_if.average_fixed),
   .maximum          (rsp_if.maximum),
   .last             (rsp_if.last)
);
